// ===== rtl/core/bba_pkg.sv =====
// Package for the buddy block allocator: sizes, table entry layout,
// controller states and datapath operation codes. No dependencies.
`default_nettype none

package bba_pkg;

   localparam int POOL_ORDER = 20;
   localparam int MIN_ORDER  = 6;
   localparam int GRAN_W     = POOL_ORDER - MIN_ORDER;   // granule index width
   localparam int ORD_W      = 5;
   localparam int ENT_W      = 7;
   localparam int CNT_W      = 15;
   localparam int ADDR_W     = 20;
   localparam int SIZE_W     = 21;
   localparam int CFG_W      = 6;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   localparam logic [1:0] REG_POOL_SIZE      = 2'd0;
   localparam logic [1:0] REG_OVERHEAD_BYTES = 2'd1;
   localparam logic [1:0] REG_PAYLOAD_OFFSET = 2'd2;

   // entry tags: bit 6 block start, bit 5 allocated
   localparam logic [1:0] TAG_FREE  = 2'b10;
   localparam logic [1:0] TAG_ALLOC = 2'b11;

   typedef enum logic [3:0] {
      S_CLR, S_LAY, S_IDLE, S_A_RD, S_A_EV, S_A_END, S_A_SPLIT,
      S_F_RD, S_F_EV, S_F_BRD, S_F_BEV, S_F_MRG, S_RESP
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_CLR, OP_LAY, OP_LOAD, OP_SCAN_RD, OP_SCAN_EV, OP_SPLIT,
      OP_ALLOC_WR, OP_FREE_RD, OP_FREE_WR, OP_BUD_RD, OP_BUD_ZERO, OP_BUD_MRG
   } op_type;

   typedef struct packed {
      logic clr_last;
      logic lay_last;
      logic want_ok;
      logic scan_end;
      logic hit;
      logic split_done;
      logic free_addr_ok;
      logic free_ent_ok;
      logic top_order;
      logic bud_match;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/bba_ctrl.sv =====
// Controller state machine of the buddy allocator: sequences clear, layout,
// alloc scan/split and free/merge. Depends on bba_pkg.
`default_nettype none

module bba_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_fire,
   input  wire logic [1:0]         req_cmd,
   input  wire bba_pkg::status_type stat,
   input  wire logic               rsp_free,
   output bba_pkg::op_type         op,
   output logic                    idle,
   output logic                    rsp_load,
   output logic                    rsp_ok
);
   import bba_pkg::*;

   state_type state_ff, state_in;
   logic      ok_ff, ok_in;
   logic      respond_ff, respond_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         ok_ff      <= 1'b0;
         respond_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ok_ff      <= ok_in;
         respond_ff <= respond_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ok_in      = ok_ff;
      respond_in = respond_ff;
      op         = OP_NONE;
      idle       = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         S_CLR: begin
            op = OP_CLR;
            if (stat.clr_last) state_in = S_LAY;
         end
         S_LAY: begin
            op = OP_LAY;
            if (stat.lay_last) begin
               ok_in    = 1'b1;
               state_in = respond_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            idle = 1'b1;
            if (req_fire) begin
               op = OP_LOAD;
               ok_in = 1'b0;
               unique case (req_cmd)
                  CMD_ALLOC:   state_in = S_A_RD;
                  CMD_FREE:    state_in = S_F_RD;
                  CMD_RESTART: begin
                     respond_in = 1'b1;
                     state_in   = S_CLR;
                  end
                  default:     state_in = S_RESP;
               endcase
            end
         end
         S_A_RD: begin
            if (!stat.want_ok) state_in = S_RESP;
            else begin
               op = OP_SCAN_RD;
               state_in = S_A_EV;
            end
         end
         S_A_EV: begin
            op = OP_SCAN_EV;
            state_in = stat.scan_end ? S_A_END : S_A_RD;
         end
         S_A_END: begin
            state_in = stat.hit ? S_A_SPLIT : S_RESP;
         end
         S_A_SPLIT: begin
            if (stat.split_done) begin
               op = OP_ALLOC_WR;
               ok_in = 1'b1;
               state_in = S_RESP;
            end else begin
               op = OP_SPLIT;
            end
         end
         S_F_RD: begin
            if (!stat.free_addr_ok) state_in = S_RESP;
            else begin
               op = OP_FREE_RD;
               state_in = S_F_EV;
            end
         end
         S_F_EV: begin
            if (!stat.free_ent_ok) state_in = S_RESP;
            else begin
               op = OP_FREE_WR;
               ok_in = 1'b1;
               state_in = S_F_BRD;
            end
         end
         S_F_BRD: begin
            if (stat.top_order) state_in = S_RESP;
            else begin
               op = OP_BUD_RD;
               state_in = S_F_BEV;
            end
         end
         S_F_BEV: begin
            if (stat.bud_match) begin
               op = OP_BUD_ZERO;
               state_in = S_F_MRG;
            end else begin
               state_in = S_RESP;
            end
         end
         S_F_MRG: begin
            op = OP_BUD_MRG;
            state_in = S_F_BRD;
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_load   = 1'b1;
               respond_in = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_ok = ok_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bba_dp.sv =====
// Datapath of the buddy allocator: block table memory, scan/split/merge
// registers and the allocation count. Depends on bba_pkg.
`default_nettype none

module bba_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bba_pkg::op_type             op,
   input  wire logic [bba_pkg::SIZE_W-1:0]  req_size,
   input  wire logic [bba_pkg::ADDR_W-1:0]  address,
   input  wire logic [bba_pkg::SIZE_W-1:0]  pool_size,
   input  wire logic [bba_pkg::CFG_W-1:0]   overhead_bytes,
   input  wire logic [bba_pkg::CFG_W-1:0]   payload_offset,
   output bba_pkg::status_type              stat,
   output logic [bba_pkg::ADDR_W-1:0]       res_addr,
   output logic [bba_pkg::CNT_W-1:0]        used_count
);
   import bba_pkg::*;

   localparam int GRANULES = 1 << GRAN_W;

   logic [ENT_W-1:0]  mem [GRANULES];
   logic [ENT_W-1:0]  rdata_ff;

   logic [SIZE_W-1:0] size_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [GRAN_W-1:0] ptr_ff, ptr_in;
   logic [ORD_W-1:0]  k_ff, k_in;
   logic [SIZE_W-1:0] off_ff, off_in;
   logic [ORD_W-1:0]  best_ff, best_in;
   logic [GRAN_W-1:0] found_ff, found_in;
   logic              hit_ff, hit_in;
   logic [GRAN_W-1:0] g_ff, g_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] res_ff, res_in;

   logic              we;
   logic [GRAN_W-1:0] maddr;
   logic [ENT_W-1:0]  wdata;

   logic [SIZE_W:0]   need;
   logic [ORD_W-1:0]  want;
   logic              want_ok;
   logic [SIZE_W-1:0] lim;
   logic              fits;
   logic [ORD_W-1:0]  rd_ord;
   logic              rd_ord_ok;
   logic [GRAN_W:0]   step;
   logic [GRAN_W:0]   nxt;
   logic [ADDR_W-1:0] foff;
   logic [GRAN_W-1:0] bud;
   logic [GRAN_W-1:0] lo_g, hi_g;

   assign need = {1'b0, size_ff} + {{(SIZE_W-CFG_W+1){1'b0}}, overhead_bytes};

   always_comb begin
      want = ORD_W'(POOL_ORDER);
      for (int i = POOL_ORDER; i >= MIN_ORDER; i--) begin
         if (need <= ((SIZE_W+1)'(1) << i)) want = ORD_W'(i);
      end
   end
   assign want_ok = need <= ((SIZE_W+1)'(1) << POOL_ORDER);

   assign lim  = (pool_size > (SIZE_W'(1) << POOL_ORDER)) ?
                 (SIZE_W'(1) << POOL_ORDER) : pool_size;
   assign fits = ({1'b0, off_ff} + ((SIZE_W+1)'(1) << k_ff)) <= {1'b0, lim};

   assign rd_ord    = rdata_ff[ORD_W-1:0];
   assign rd_ord_ok = (rd_ord >= ORD_W'(MIN_ORDER)) && (rd_ord <= ORD_W'(POOL_ORDER));
   assign step      = rd_ord_ok ? ((GRAN_W+1)'(1) << (rd_ord - ORD_W'(MIN_ORDER)))
                                : (GRAN_W+1)'(1);
   assign nxt       = {1'b0, ptr_ff} + step;

   assign foff = addr_ff - {{(ADDR_W-CFG_W){1'b0}}, payload_offset};
   assign bud  = g_ff ^ (GRAN_W'(1) << (k_ff - ORD_W'(MIN_ORDER)));
   assign lo_g = (bud < g_ff) ? bud : g_ff;
   assign hi_g = (bud < g_ff) ? g_ff : bud;

   always_comb begin
      stat.clr_last     = &ptr_ff;
      stat.lay_last     = k_ff == ORD_W'(MIN_ORDER);
      stat.want_ok      = want_ok;
      stat.scan_end     = !rdata_ff[6] || nxt[GRAN_W];
      stat.hit          = hit_ff;
      stat.split_done   = best_ff == want;
      stat.free_addr_ok = (addr_ff >= {{(ADDR_W-CFG_W){1'b0}}, payload_offset})
                          && (foff[MIN_ORDER-1:0] == '0);
      stat.free_ent_ok  = rdata_ff[6] && rdata_ff[5] && rd_ord_ok;
      stat.top_order    = k_ff == ORD_W'(POOL_ORDER);
      stat.bud_match    = rdata_ff == {TAG_FREE, k_ff};
   end

   always_comb begin
      we       = 1'b0;
      maddr    = ptr_ff;
      wdata    = '0;
      ptr_in   = ptr_ff;
      k_in     = k_ff;
      off_in   = off_ff;
      best_in  = best_ff;
      found_in = found_ff;
      hit_in   = hit_ff;
      g_in     = g_ff;
      count_in = count_ff;
      res_in   = res_ff;
      unique case (op)
         OP_CLR: begin
            we     = 1'b1;
            ptr_in = ptr_ff + GRAN_W'(1);
            if (&ptr_ff) begin
               k_in     = ORD_W'(POOL_ORDER);
               off_in   = '0;
               count_in = '0;
            end
         end
         OP_LAY: begin
            we    = fits;
            maddr = off_ff[ADDR_W-1:MIN_ORDER];
            wdata = {TAG_FREE, k_ff};
            if (fits) off_in = off_ff + (SIZE_W'(1) << k_ff);
            k_in  = k_ff - ORD_W'(1);
         end
         OP_LOAD: begin
            ptr_in  = '0;
            best_in = '1;
            hit_in  = 1'b0;
            res_in  = '0;
         end
         OP_SCAN_RD: maddr = ptr_ff;
         OP_SCAN_EV: begin
            if (rdata_ff[6] && !rdata_ff[5] && rd_ord >= want && rd_ord < best_ff) begin
               best_in  = rd_ord;
               found_in = ptr_ff;
               hit_in   = 1'b1;
            end
            ptr_in = nxt[GRAN_W-1:0];
         end
         OP_SPLIT: begin
            we      = 1'b1;
            maddr   = found_ff + (GRAN_W'(1) << (best_ff - ORD_W'(MIN_ORDER + 1)));
            wdata   = {TAG_FREE, best_ff - ORD_W'(1)};
            best_in = best_ff - ORD_W'(1);
         end
         OP_ALLOC_WR: begin
            we       = 1'b1;
            maddr    = found_ff;
            wdata    = {TAG_ALLOC, want};
            count_in = count_ff + CNT_W'(1);
            res_in   = {found_ff, {MIN_ORDER{1'b0}}}
                       + {{(ADDR_W-CFG_W){1'b0}}, payload_offset};
         end
         OP_FREE_RD: begin
            maddr = foff[ADDR_W-1:MIN_ORDER];
            g_in  = foff[ADDR_W-1:MIN_ORDER];
         end
         OP_FREE_WR: begin
            we       = 1'b1;
            maddr    = g_ff;
            wdata    = {TAG_FREE, rd_ord};
            k_in     = rd_ord;
            count_in = count_ff - CNT_W'(1);
         end
         OP_BUD_RD: maddr = bud;
         OP_BUD_ZERO: begin
            we    = 1'b1;
            maddr = hi_g;
         end
         OP_BUD_MRG: begin
            we    = 1'b1;
            maddr = lo_g;
            wdata = {TAG_FREE, k_ff + ORD_W'(1)};
            g_in  = lo_g;
            k_in  = k_ff + ORD_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[maddr] <= wdata;
      rdata_ff <= mem[maddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         count_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         ptr_ff   <= ptr_in;
         count_ff <= count_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op == OP_LOAD) begin
         size_ff <= req_size;
         addr_ff <= address;
      end
      k_ff     <= k_in;
      off_ff   <= off_in;
      best_ff  <= best_in;
      found_ff <= found_in;
      g_ff     <= g_in;
      res_ff   <= res_in;
   end

   assign res_addr   = res_ff;
   assign used_count = count_ff;

endmodule

`default_nettype wire

// ===== rtl/core/buddy_block_allocator_unit.sv =====
// Top level of the buddy block allocator: register port, result register,
// controller and datapath. Depends on bba_pkg, bba_ctrl, bba_dp.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | cmd, req_size, address
//   rsp     | out       | rsp_valid/stall   | ok, result_address, used_count
//   csr     | in/out    | psel/penable      | paddr, pwdata, prdata
//
// One item at a time. Alloc: a scan reads each block walked in the table in
// turn (one memory read port), then one table write per split level. Free:
// an entry read and write, then a buddy read and merge per level. Restart and
// reset: a clearing pass over all 16384 table entries plus the layout of the free blocks; no item is taken meanwhile.
// The next item is taken while a result waits in the output register.
`default_nettype none

module buddy_block_allocator_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_cmd,
   input  wire logic [bba_pkg::SIZE_W-1:0] req_req_size,
   input  wire logic [bba_pkg::ADDR_W-1:0] req_address,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_ok,
   output logic [bba_pkg::ADDR_W-1:0]      rsp_result_address,
   output logic [bba_pkg::CNT_W-1:0]       rsp_used_count,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [3:0]                 paddr,
   input  wire logic [31:0]                pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import bba_pkg::*;

   logic [SIZE_W-1:0] pool_size_ff;
   logic [CFG_W-1:0]  overhead_ff;
   logic [CFG_W-1:0]  payload_ff;
   logic              csr_wr;

   op_type            op;
   status_type        stat;
   logic              idle, rsp_load, ok;
   logic              req_fire, rsp_free;
   logic [ADDR_W-1:0] res_addr;
   logic [CNT_W-1:0]  used_count;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff <= SIZE_W'(1) << POOL_ORDER;
         overhead_ff  <= CFG_W'(28);
         payload_ff   <= CFG_W'(24);
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            REG_POOL_SIZE:      pool_size_ff <= pwdata[SIZE_W-1:0];
            REG_OVERHEAD_BYTES: overhead_ff  <= pwdata[CFG_W-1:0];
            REG_PAYLOAD_OFFSET: payload_ff   <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_POOL_SIZE:      prdata = {{(32-SIZE_W){1'b0}}, pool_size_ff};
         REG_OVERHEAD_BYTES: prdata = {{(32-CFG_W){1'b0}}, overhead_ff};
         REG_PAYLOAD_OFFSET: prdata = {{(32-CFG_W){1'b0}}, payload_ff};
         default:            prdata = '0;
      endcase
   end

   assign req_stall = !idle;
   assign req_fire  = req_valid && idle;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   bba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_cmd  (req_cmd),
      .stat     (stat),
      .rsp_free (rsp_free),
      .op       (op),
      .idle     (idle),
      .rsp_load (rsp_load),
      .rsp_ok   (ok)
   );

   bba_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .op             (op),
      .req_size       (req_req_size),
      .address        (req_address),
      .pool_size      (pool_size_ff),
      .overhead_bytes (overhead_ff),
      .payload_offset (payload_ff),
      .stat           (stat),
      .res_addr       (res_addr),
      .used_count     (used_count)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ok_ff   <= ok;
         rsp_addr_ff <= res_addr;
         rsp_cnt_ff  <= used_count;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_used_count     = rsp_cnt_ff;

   // a failed transaction never reports an address
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_result_address == '0)
      else $error("failed result carries an address");

   // results are loaded only from the response state, never while idle
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !idle)
      else $error("result loaded while idle");

   // an accepted item always leaves the idle state
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> req_stall)
      else $error("still idle after accepting a transaction");

endmodule

`default_nettype wire

// ===== sim/buddy_block_allocator_unit_checker.sv =====
// Checker for the buddy block allocator: watches the register port and both
// channels, keeps its own copy of the block table and compares each result.
// Depends on bba_pkg.
module buddy_block_allocator_unit_checker
   import bba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [SIZE_W-1:0] req_req_size,
   input  logic [ADDR_W-1:0] req_address,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_ok,
   input  logic [ADDR_W-1:0] rsp_result_address,
   input  logic [CNT_W-1:0]  rsp_used_count,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   input  logic              pready,
   output int                fail_count,
   output int                outstanding
);

   localparam int NGRAN = 1 << GRAN_W;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] addr;
      logic [CNT_W-1:0]  used;
   } alloc_result_type;

   logic [ENT_W-1:0] blk_tbl [0:NGRAN-1];
   logic [CNT_W-1:0] used_blocks;
   logic [SIZE_W-1:0] pool_bytes;
   logic [CFG_W-1:0]  hdr_bytes;
   logic [CFG_W-1:0]  pay_off;
   alloc_result_type  expected_q [$];

   function automatic logic [ENT_W-1:0] free_ent(int k);
      return {TAG_FREE, k[ORD_W-1:0]};
   endfunction

   function automatic void lay_pool();
      longint lim;
      longint off;
      lim = pool_bytes;
      off = 0;
      if (lim > (64'd1 << POOL_ORDER)) lim = 64'd1 << POOL_ORDER;
      for (int g = 0; g < NGRAN; g++) blk_tbl[g] = '0;
      used_blocks = '0;
      for (int k = POOL_ORDER; k >= MIN_ORDER; k--) begin
         if (off + (64'd1 << k) <= lim) begin
            blk_tbl[off >> MIN_ORDER] = free_ent(k);
            off += 64'd1 << k;
         end
      end
   endfunction

   function automatic logic alloc_block(longint size, output logic [ADDR_W-1:0] addr);
      longint need;
      int want;
      int found;
      int j;
      bit hit;
      need = size + hdr_bytes;
      want = -1;
      found = 0;
      hit = 0;
      addr = '0;
      for (int k = MIN_ORDER; k <= POOL_ORDER; k++)
         if (want < 0 && (64'd1 << k) >= need) want = k;
      if (want < 0) return 1'b0;
      for (j = want; j <= POOL_ORDER && !hit; j++)
         for (int g = 0; g < NGRAN && !hit; g += (1 << (j - MIN_ORDER)))
            if (blk_tbl[g] == free_ent(j)) begin
               found = g;
               hit = 1;
            end
      if (!hit) return 1'b0;
      j = blk_tbl[found][ORD_W-1:0];
      while (j > want) begin
         j--;
         blk_tbl[found + (1 << (j - MIN_ORDER))] = free_ent(j);
      end
      blk_tbl[found] = {TAG_ALLOC, want[ORD_W-1:0]};
      used_blocks = used_blocks + 1'b1;
      addr = ADDR_W'((longint'(found) << MIN_ORDER) + pay_off);
      return 1'b1;
   endfunction

   function automatic logic free_block(logic [ADDR_W-1:0] address);
      longint off;
      int g;
      int b;
      int k;
      if (address < pay_off) return 1'b0;
      off = address - pay_off;
      if (off[MIN_ORDER-1:0] != 0) return 1'b0;
      if ((off >> MIN_ORDER) >= NGRAN) return 1'b0;
      g = off >> MIN_ORDER;
      if (blk_tbl[g][ENT_W-1:ORD_W] != TAG_ALLOC) return 1'b0;
      k = blk_tbl[g][ORD_W-1:0];
      if (k < MIN_ORDER || k > POOL_ORDER) return 1'b0;
      blk_tbl[g] = free_ent(k);
      used_blocks = used_blocks - 1'b1;
      while (k < POOL_ORDER) begin
         b = g ^ (1 << (k - MIN_ORDER));
         if (b >= NGRAN || blk_tbl[b] != free_ent(k)) break;
         blk_tbl[b] = '0;
         blk_tbl[g] = '0;
         if (b < g) g = b;
         k++;
         blk_tbl[g] = free_ent(k);
      end
      return 1'b1;
   endfunction

   assign outstanding = expected_q.size();

   always @(posedge clock) begin
      alloc_result_type want_r;
      alloc_result_type got;
      logic [ADDR_W-1:0] a;
      if (reset) begin
         pool_bytes = 21'd1048576;
         hdr_bytes = 6'd28;
         pay_off = 6'd24;
         lay_pool();
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_POOL_SIZE:      pool_bytes = pwdata[SIZE_W-1:0];
               REG_OVERHEAD_BYTES: hdr_bytes = pwdata[CFG_W-1:0];
               REG_PAYLOAD_OFFSET: pay_off = pwdata[CFG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            want_r = '0;
            case (req_cmd)
               CMD_ALLOC: begin
                  want_r.ok = alloc_block(req_req_size, a);
                  want_r.addr = want_r.ok ? a : '0;
               end
               CMD_FREE:    want_r.ok = free_block(req_address);
               CMD_RESTART: begin
                  lay_pool();
                  want_r.ok = 1'b1;
               end
               default: ;
            endcase
            want_r.used = used_blocks;
            expected_q.push_back(want_r);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_ok, rsp_result_address, rsp_used_count};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected transaction ok=%0d addr=%0h used=%0d",
                        $time, got.ok, got.addr, got.used);
               fail_count <= fail_count + 1;
            end else begin
               want_r = expected_q.pop_front();
               if (got != want_r) begin
                  $display("%0t: mismatch exp ok=%0d addr=%0h used=%0d, got ok=%0d addr=%0h used=%0d",
                           $time, want_r.ok, want_r.addr, want_r.used,
                           got.ok, got.addr, got.used);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== sim/buddy_block_allocator_unit_tb.sv =====
// Testbench top for the buddy block allocator: clock, reset, register writes
// and request stimulus, verdict. Depends on bba_pkg, the block and its checker.
module buddy_block_allocator_unit_tb;
   import bba_pkg::*;

   // command code outside the defined set
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_cmd;
   logic [SIZE_W-1:0] req_req_size;
   logic [ADDR_W-1:0] req_address;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_ok;
   logic [ADDR_W-1:0] rsp_result_address;
   logic [CNT_W-1:0]  rsp_used_count;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [3:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;
   int                fail_count;
   int                outstanding;

   logic [1:0]        sent_cmds [$];
   logic [ADDR_W-1:0] live_addrs [$];
   int                burst_left;

   buddy_block_allocator_unit u_dut (.*);

   buddy_block_allocator_unit_checker u_chk (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400000000;
      $display("buddy_block_allocator_unit regression: fail");
      $finish;
   end

   // track granted blocks so frees mostly hit live allocations
   always @(posedge clock) begin
      logic [1:0] c;
      if (!reset) begin
         if (req_valid && !req_stall) sent_cmds.push_back(req_cmd);
         if (rsp_valid && !rsp_stall && sent_cmds.size() > 0) begin
            c = sent_cmds.pop_front();
            if (c == CMD_ALLOC && rsp_ok) live_addrs.push_back(rsp_result_address);
            if (c == CMD_RESTART) live_addrs.delete();
         end
      end
   end

   // receiver: long hold-off once traffic flows, then no/light/heavy stall
   initial begin
      int seg;
      int mode;
      rsp_stall <= 1'b0;
      seg = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      // table clearing after reset takes a while; wait for the first result
      while (!rsp_valid) @(posedge clock);
      forever begin
         seg++;
         if (seg == 1) begin
            repeat (800) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(50, 400)) begin
            @(posedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic send(logic [1:0] cmd, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_req_size <= size;
      req_address <= addr;
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic rand_item(logic [CFG_W-1:0] poff);
      int pick;
      int idx;
      logic [SIZE_W-1:0] sz;
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: sz = SIZE_W'($urandom_range(0, 200));
            6, 7: sz = SIZE_W'($urandom_range(0, 5000));
            8: sz = SIZE_W'($urandom_range(0, 70000));
            default: sz = SIZE_W'($urandom);
         endcase
         send(CMD_ALLOC, sz, ADDR_W'($urandom));
      end else if (pick < 88 && live_addrs.size() > 0) begin
         idx = $urandom_range(0, live_addrs.size() - 1);
         send(CMD_FREE, SIZE_W'($urandom), live_addrs[idx]);
         live_addrs.delete(idx);
      end else if (pick < 95) begin
         if ($urandom_range(0, 1))
            send(CMD_FREE, SIZE_W'($urandom),
                 ADDR_W'(($urandom_range(0, 1023) << MIN_ORDER) + poff));
         else
            send(CMD_FREE, SIZE_W'($urandom), ADDR_W'($urandom));
      end else if (pick < 99) begin
         send(CMD_UNUSED, SIZE_W'($urandom), ADDR_W'($urandom));
      end else begin
         send(CMD_RESTART, SIZE_W'($urandom), ADDR_W'($urandom));
      end
   endtask

   initial begin
      logic [31:0] pools [6];
      logic [5:0]  ovhs [6];
      logic [5:0]  poffs [6];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= CMD_ALLOC;
      req_req_size <= '0;
      req_address <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      burst_left = 0;
      pools = '{32'd1048576, 32'd64, 32'd1048576, 32'd1000, 32'd2097151, 32'd100};
      ovhs = '{6'd28, 6'd0, 6'd63, 6'd5, 6'd28, 6'd63};
      poffs = '{6'd24, 6'd0, 6'd63, 6'd17, 6'd42, 6'd0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, reset configuration
      send(CMD_ALLOC, 21'd0, '0);
      send(CMD_ALLOC, 21'd1048576, '0);
      send(CMD_ALLOC, 21'h1FFFFF, '0);
      send(CMD_ALLOC, 21'd1048548, '0);
      send(CMD_FREE, '0, 20'd0);
      send(CMD_FREE, '0, 20'd25);
      send(CMD_FREE, '0, 20'd88);
      send(CMD_FREE, '0, 20'hFFFFF);
      send(CMD_FREE, '0, 20'd24);
      send(CMD_FREE, '0, 20'd24);
      send(CMD_UNUSED, 21'h1FFFFF, 20'hFFFFF);
      send(CMD_ALLOC, 21'd100, '0);
      send(CMD_ALLOC, 21'd36, '0);
      send(CMD_ALLOC, 21'd37, '0);
      send(CMD_FREE, '0, 20'd24);
      send(CMD_RESTART, '0, '0);
      send(CMD_ALLOC, 21'd1048548, '0);
      send(CMD_ALLOC, 21'd0, '0);
      send(CMD_FREE, '0, 20'd24);
      send(CMD_ALLOC, 21'd1048549, '0);
      drain();

      for (int p = 0; p < 6; p++) begin
         csr_write(REG_POOL_SIZE, pools[p]);
         csr_write(REG_OVERHEAD_BYTES, 32'(ovhs[p]));
         csr_write(REG_PAYLOAD_OFFSET, 32'(poffs[p]));
         send(CMD_RESTART, '0, '0);
         repeat (150) rand_item(poffs[p]);
         drain();
      end

      if (fail_count == 0)
         $display("buddy_block_allocator_unit regression: pass");
      else
         $display("buddy_block_allocator_unit regression: fail");
      $finish;
   end

endmodule

// ===== buddy_block_allocator_unit.f =====
rtl/core/bba_pkg.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_dp.sv
rtl/core/buddy_block_allocator_unit.sv
sim/buddy_block_allocator_unit_checker.sv
sim/buddy_block_allocator_unit_tb.sv
